@@ hdl/lss_pkg.sv @@
// Shared types and constants for the lidar sector summary block.
// Holds the register map, the scan job and result records and the arctangent table.
// No dependencies.
`default_nettype none
package lss_pkg;

   typedef enum logic [2:0] {
      REG_FRONT_LOW_END    = 3'd0,
      REG_LEFT_END         = 3'd1,
      REG_RIGHT_START      = 3'd2,
      REG_FRONT_HIGH_START = 3'd3,
      REG_POSE_X           = 3'd4,
      REG_POSE_Y           = 3'd5,
      REG_POSE_HEADING     = 3'd6,
      REG_POSE_VALID       = 3'd7
   } reg_index_type;

   localparam logic [25:0] SUM_MAX     = 26'h3FF_FFFF;
   localparam logic [10:0] COUNT_MAX   = 11'd2047;
   localparam int          ATAN_ENTRIES = 24;
   localparam int          RUN_STEPS    = 26;

   typedef struct packed {
      logic        [9:0]  front_low_end;
      logic        [9:0]  left_end;
      logic        [9:0]  right_start;
      logic        [9:0]  front_high_start;
      logic signed [23:0] pose_x;
      logic signed [23:0] pose_y;
      logic signed [15:0] pose_heading;
      logic               pose_valid;
   } cfg_type;

   typedef struct packed {
      logic        [15:0] front_min;
      logic        [25:0] left_sum;
      logic        [10:0] left_count;
      logic        [25:0] right_sum;
      logic        [10:0] right_count;
      logic signed [23:0] goal_x;
      logic signed [23:0] goal_y;
   } job_type;

   typedef struct packed {
      logic               summary_valid;
      logic        [15:0] front_min_mm;
      logic        [15:0] left_avg_mm;
      logic        [15:0] right_avg_mm;
      logic        [24:0] goal_distance_mm;
      logic signed [15:0] heading_error;
   } res_type;

   // arctan(2^-i) as a fraction of one full turn, 2^32 per turn
   localparam logic [31:0] ATAN_TURN [ATAN_ENTRIES] = '{
      32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4, 32'h028B0D43, 32'h0145D7E1,
      32'h00A2F61E, 32'h00517C55, 32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
      32'h00028BE6, 32'h000145F3, 32'h0000A2FA, 32'h0000517D, 32'h000028BE, 32'h0000145F,
      32'h00000A30, 32'h00000518, 32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051
   };

endpackage
`default_nettype wire

@@ hdl/lss_front.sv @@
// Front end of the lidar sector summary: classifies each sample and accumulates sectors.
// Depends on lss_pkg; hands a finished scan to the job queue on the last sample.
`default_nettype none
module lss_front #(
   parameter int MAX_BEAMS    = 1024,
   parameter int NO_RETURN_MM = 10000
) (
   input  wire              clock,
   input  wire              reset,
   input  wire              req_valid,
   output logic             req_ready,
   input  wire  [15:0]      range_mm,
   input  wire  [9:0]       beam_index,
   input  wire              last_sample,
   input  wire  [23:0]      goal_x,
   input  wire  [23:0]      goal_y,
   input  lss_pkg::cfg_type cfg,
   input  wire              queue_full,
   output logic             push,
   output lss_pkg::job_type push_job
);
   import lss_pkg::*;

   localparam logic [15:0] NO_RET = 16'(NO_RETURN_MM);

   logic [15:0] min_ff, min_in;
   logic [25:0] lsum_ff, lsum_in, rsum_ff, rsum_in;
   logic [10:0] lcnt_ff, lcnt_in, rcnt_ff, rcnt_in;
   logic [15:0] range_sub;
   logic [26:0] lsum_add, rsum_add;
   logic        accept, in_range, is_front, is_left, is_right;

   assign req_ready = !queue_full;
   assign accept    = req_valid && req_ready;
   assign range_sub = (range_mm == 16'd0 || range_mm == 16'hFFFF) ? NO_RET : range_mm;
   assign in_range  = {3'b000, beam_index} < 13'(MAX_BEAMS);
   assign is_front  = in_range && (beam_index <= cfg.front_low_end ||
                                   beam_index >= cfg.front_high_start);
   assign is_left   = in_range && !is_front && beam_index <= cfg.left_end;
   assign is_right  = in_range && !is_front && !is_left && beam_index >= cfg.right_start;
   assign lsum_add  = {1'b0, lsum_ff} + {11'd0, range_sub};
   assign rsum_add  = {1'b0, rsum_ff} + {11'd0, range_sub};

   always_comb begin
      min_in  = min_ff;
      lsum_in = lsum_ff;
      lcnt_in = lcnt_ff;
      rsum_in = rsum_ff;
      rcnt_in = rcnt_ff;
      if (is_front && range_sub < min_ff) begin
         min_in = range_sub;
      end
      if (is_left) begin
         lsum_in = lsum_add[26] ? SUM_MAX : lsum_add[25:0];
         lcnt_in = (lcnt_ff == COUNT_MAX) ? lcnt_ff : lcnt_ff + 11'd1;
      end
      if (is_right) begin
         rsum_in = rsum_add[26] ? SUM_MAX : rsum_add[25:0];
         rcnt_in = (rcnt_ff == COUNT_MAX) ? rcnt_ff : rcnt_ff + 11'd1;
      end
   end

   assign push = accept && last_sample;
   always_comb begin
      push_job.front_min   = min_in;
      push_job.left_sum    = lsum_in;
      push_job.left_count  = lcnt_in;
      push_job.right_sum   = rsum_in;
      push_job.right_count = rcnt_in;
      push_job.goal_x      = goal_x;
      push_job.goal_y      = goal_y;
   end

   always_ff @(posedge clock) begin
      if (reset || push) begin
         min_ff  <= NO_RET;
         lsum_ff <= '0;
         lcnt_ff <= '0;
         rsum_ff <= '0;
         rcnt_ff <= '0;
      end else if (accept) begin
         min_ff  <= min_in;
         lsum_ff <= lsum_in;
         lcnt_ff <= lcnt_in;
         rsum_ff <= rsum_in;
         rcnt_ff <= rcnt_in;
      end
   end
endmodule
`default_nettype wire

@@ hdl/lss_queue.sv @@
// Two-entry queue of finished scan jobs between the front and back ends.
// Depends on lss_pkg for the job record.
`default_nettype none
module lss_queue (
   input  wire              clock,
   input  wire              reset,
   input  wire              push,
   input  lss_pkg::job_type push_job,
   output logic             full,
   input  wire              pop,
   output lss_pkg::job_type pop_job,
   output logic             not_empty
);
   import lss_pkg::*;

   job_type    mem_ff [2];
   logic       wr_ptr_ff, rd_ptr_ff;
   logic [1:0] count_ff;

   assign full      = (count_ff == 2'd2);
   assign not_empty = (count_ff != 2'd0);
   assign pop_job   = mem_ff[rd_ptr_ff];

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_job;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         if (push) begin
            wr_ptr_ff <= !wr_ptr_ff;
         end
         if (pop) begin
            rd_ptr_ff <= !rd_ptr_ff;
         end
         case ({push, pop})
            2'b10:   count_ff <= count_ff + 2'd1;
            2'b01:   count_ff <= count_ff - 2'd1;
            default: count_ff <= count_ff;
         endcase
      end
   end
endmodule
`default_nettype wire

@@ hdl/lss_back.sv @@
// Back end: per-scan averages, goal distance and bearing error, one step a cycle.
// Depends on lss_pkg; takes jobs from lss_queue and holds the result register.
`default_nettype none
module lss_back #(
   parameter int CORDIC_STEPS = 16
) (
   input  wire              clock,
   input  wire              reset,
   input  lss_pkg::cfg_type cfg,
   input  wire              job_ready,
   input  lss_pkg::job_type job,
   output logic             pop,
   output logic             rsp_valid,
   input  wire              rsp_ready,
   output lss_pkg::res_type result
);
   import lss_pkg::*;

   typedef enum logic [2:0] {ST_IDLE, ST_MUL_X, ST_MUL_Y, ST_RUN, ST_DONE} state_type;

   state_type          state_ff, state_in;
   job_type            job_ff, job_in;
   logic signed [24:0] dx_ff, dx_in, dy_ff, dy_in;
   logic        [4:0]  iter_ff, iter_in;
   logic        [50:0] sq_rem_ff, sq_rem_in, sq_r_ff, sq_r_in, sq_bit_ff, sq_bit_in;
   logic        [11:0] lrem_ff, lrem_in, rrem_ff, rrem_in;
   logic        [25:0] lnum_ff, lnum_in, rnum_ff, rnum_in, lq_ff, lq_in, rq_ff, rq_in;
   logic signed [57:0] cx_ff, cx_in, cy_ff, cy_in;
   logic        [31:0] cz_ff, cz_in;
   logic               zero_ff, zero_in;
   logic               out_valid_ff, out_valid_in;
   res_type            out_ff, out_in;

   logic signed [24:0] dx_new, dy_new, mul_op;
   logic signed [49:0] prod;
   logic signed [57:0] xs, ys, x0, y0;
   logic        [50:0] trial;
   logic        [11:0] lt, rt;
   logic        [31:0] err;
   logic        [24:0] root_rnd;
   logic               out_free;

   assign dx_new   = 25'(job.goal_x) - 25'(cfg.pose_x);
   assign dy_new   = 25'(job.goal_y) - 25'(cfg.pose_y);
   assign mul_op   = (state_ff == ST_MUL_X) ? dx_ff : dy_ff;
   assign prod     = mul_op * mul_op;
   assign x0       = 58'(dx_new) <<< 30;
   assign y0       = 58'(dy_new) <<< 30;
   assign xs       = cx_ff >>> iter_ff;
   assign ys       = cy_ff >>> iter_ff;
   assign trial    = sq_r_ff + sq_bit_ff;
   assign lt       = {lrem_ff[10:0], lnum_ff[25]};
   assign rt       = {rrem_ff[10:0], rnum_ff[25]};
   assign err      = cz_ff - {cfg.pose_heading, 16'd0} + 32'h0000_8000;
   assign root_rnd = (sq_rem_ff > sq_r_ff) ? sq_r_ff[24:0] + 25'd1 : sq_r_ff[24:0];
   assign out_free = !out_valid_ff || rsp_ready;
   assign pop      = (state_ff == ST_IDLE) && job_ready;

   assign rsp_valid = out_valid_ff;
   assign result    = out_ff;

   always_comb begin
      state_in     = state_ff;
      job_in       = job_ff;
      dx_in        = dx_ff;
      dy_in        = dy_ff;
      iter_in      = iter_ff;
      sq_rem_in    = sq_rem_ff;
      sq_r_in      = sq_r_ff;
      sq_bit_in    = sq_bit_ff;
      lrem_in      = lrem_ff;
      rrem_in      = rrem_ff;
      lnum_in      = lnum_ff;
      rnum_in      = rnum_ff;
      lq_in        = lq_ff;
      rq_in        = rq_ff;
      cx_in        = cx_ff;
      cy_in        = cy_ff;
      cz_in        = cz_ff;
      zero_in      = zero_ff;
      out_valid_in = out_valid_ff && !rsp_ready;
      out_in       = out_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (job_ready) begin
               job_in   = job;
               dx_in    = dx_new;
               dy_in    = dy_new;
               zero_in  = (dx_new == 25'sd0) && (dy_new == 25'sd0);
               // Left half-plane is turned through half a turn before vectoring.
               cx_in    = dx_new[24] ? -x0 : x0;
               cy_in    = dx_new[24] ? -y0 : y0;
               cz_in    = dx_new[24] ? 32'h8000_0000 : 32'd0;
               state_in = ST_MUL_X;
            end
         end
         ST_MUL_X: begin
            sq_rem_in = {1'b0, prod};
            state_in  = ST_MUL_Y;
         end
         ST_MUL_Y: begin
            sq_rem_in = sq_rem_ff + {1'b0, prod};
            sq_r_in   = '0;
            sq_bit_in = 51'd1 << 50;
            lrem_in   = '0;
            rrem_in   = '0;
            lnum_in   = job_ff.left_sum;
            rnum_in   = job_ff.right_sum;
            iter_in   = '0;
            state_in  = ST_RUN;
         end
         ST_RUN: begin
            if (sq_rem_ff >= trial) begin
               sq_rem_in = sq_rem_ff - trial;
               sq_r_in   = (sq_r_ff >> 1) + sq_bit_ff;
            end else begin
               sq_r_in   = sq_r_ff >> 1;
            end
            sq_bit_in = sq_bit_ff >> 2;
            if (lt >= {1'b0, job_ff.left_count}) begin
               lrem_in = lt - {1'b0, job_ff.left_count};
               lq_in   = {lq_ff[24:0], 1'b1};
            end else begin
               lrem_in = lt;
               lq_in   = {lq_ff[24:0], 1'b0};
            end
            if (rt >= {1'b0, job_ff.right_count}) begin
               rrem_in = rt - {1'b0, job_ff.right_count};
               rq_in   = {rq_ff[24:0], 1'b1};
            end else begin
               rrem_in = rt;
               rq_in   = {rq_ff[24:0], 1'b0};
            end
            lnum_in = {lnum_ff[24:0], 1'b0};
            rnum_in = {rnum_ff[24:0], 1'b0};
            if (!zero_ff && {27'd0, iter_ff} < 32'(CORDIC_STEPS)) begin
               if (cy_ff > 58'sd0) begin
                  cx_in = cx_ff + ys;
                  cy_in = cy_ff - xs;
                  cz_in = cz_ff + ATAN_TURN[iter_ff];
               end else begin
                  cx_in = cx_ff - ys;
                  cy_in = cy_ff + xs;
                  cz_in = cz_ff - ATAN_TURN[iter_ff];
               end
            end
            iter_in = iter_ff + 5'd1;
            if (iter_ff == 5'(RUN_STEPS - 1)) begin
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            if (out_free) begin
               out_in = '0;
               if (cfg.pose_valid) begin
                  out_in.summary_valid    = 1'b1;
                  out_in.front_min_mm     = job_ff.front_min;
                  out_in.left_avg_mm      = (job_ff.left_count == 11'd0) ? 16'd0 :
                                            (lq_ff[25:16] != 10'd0) ? 16'hFFFF : lq_ff[15:0];
                  out_in.right_avg_mm     = (job_ff.right_count == 11'd0) ? 16'd0 :
                                            (rq_ff[25:16] != 10'd0) ? 16'hFFFF : rq_ff[15:0];
                  out_in.goal_distance_mm = root_rnd;
                  out_in.heading_error    = err[31:16];
               end
               out_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         out_valid_ff <= out_valid_in;
      end
      job_ff    <= job_in;
      dx_ff     <= dx_in;
      dy_ff     <= dy_in;
      iter_ff   <= iter_in;
      sq_rem_ff <= sq_rem_in;
      sq_r_ff   <= sq_r_in;
      sq_bit_ff <= sq_bit_in;
      lrem_ff   <= lrem_in;
      rrem_ff   <= rrem_in;
      lnum_ff   <= lnum_in;
      rnum_ff   <= rnum_in;
      lq_ff     <= lq_in;
      rq_ff     <= rq_in;
      cx_ff     <= cx_in;
      cy_ff     <= cy_in;
      cz_ff     <= cz_in;
      zero_ff   <= zero_in;
      out_ff    <= out_in;
   end
endmodule
`default_nettype wire

@@ hdl/lidar_sector_summary.sv @@
// Lidar sector summary: one range sample per request, one summary per scan.
// Throughput: one sample request per cycle while the job queue is not full; a scan summary
// runs in the back end through the 26 one-bit steps shared by the square root, the two dividers and the CORDIC.
// Reset (synchronous, active high) restores the default sector bounds, clears the pose,
// empties the job queue and clears the sector accumulators.
`default_nettype none
module lidar_sector_summary #(
   parameter int MAX_BEAMS    = 1024,
   parameter int NO_RETURN_MM = 10000,
   parameter int CORDIC_STEPS = 16
) (
   input  wire         clock,
   input  wire         reset,
   // Sample requests.
   input  wire         req_tvalid,
   output logic        req_tready,
   // range_mm [15:0], beam_index [25:16], goal_x [49:26], goal_y [73:50], zeros above
   input  wire  [79:0] req_tdata,
   input  wire         req_tlast,
   // Summary results.
   output logic        rsp_tvalid,
   input  wire         rsp_tready,
   // front_min_mm [15:0], left_avg_mm [31:16], right_avg_mm [47:32],
   // goal_distance_mm [72:48], heading_error [88:73], zeros above
   output logic [95:0] rsp_tdata,
   // summary_valid [0]
   output logic        rsp_tuser,
   // Register port.
   input  wire         csr_psel,
   input  wire         csr_penable,
   input  wire         csr_pwrite,
   input  wire  [4:0]  csr_paddr,
   input  wire  [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);
   import lss_pkg::*;

   cfg_type       cfg_ff;
   reg_index_type csr_index;
   logic          csr_write;
   logic          push, full, pop, not_empty;
   job_type       push_job, pop_job;
   res_type       result;

   // The register port never waits; writes land in the access phase.
   assign csr_pready = 1'b1;
   assign csr_index  = reg_index_type'(csr_paddr[4:2]);
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.front_low_end    <= 10'd30;
         cfg_ff.left_end         <= 10'd90;
         cfg_ff.right_start      <= 10'd270;
         cfg_ff.front_high_start <= 10'd330;
         cfg_ff.pose_x           <= '0;
         cfg_ff.pose_y           <= '0;
         cfg_ff.pose_heading     <= '0;
         cfg_ff.pose_valid       <= 1'b0;
      end else if (csr_write) begin
         unique case (csr_index)
            REG_FRONT_LOW_END:    cfg_ff.front_low_end    <= csr_pwdata[9:0];
            REG_LEFT_END:         cfg_ff.left_end         <= csr_pwdata[9:0];
            REG_RIGHT_START:      cfg_ff.right_start      <= csr_pwdata[9:0];
            REG_FRONT_HIGH_START: cfg_ff.front_high_start <= csr_pwdata[9:0];
            REG_POSE_X:           cfg_ff.pose_x           <= csr_pwdata[23:0];
            REG_POSE_Y:           cfg_ff.pose_y           <= csr_pwdata[23:0];
            REG_POSE_HEADING:     cfg_ff.pose_heading     <= csr_pwdata[15:0];
            REG_POSE_VALID:       cfg_ff.pose_valid       <= csr_pwdata[0];
            default:              cfg_ff.pose_valid       <= cfg_ff.pose_valid;
         endcase
      end
   end

   // Reads return the stored bits, zero-extended.
   always_comb begin
      unique case (csr_index)
         REG_FRONT_LOW_END:    csr_prdata = {22'd0, cfg_ff.front_low_end};
         REG_LEFT_END:         csr_prdata = {22'd0, cfg_ff.left_end};
         REG_RIGHT_START:      csr_prdata = {22'd0, cfg_ff.right_start};
         REG_FRONT_HIGH_START: csr_prdata = {22'd0, cfg_ff.front_high_start};
         REG_POSE_X:           csr_prdata = {8'd0, cfg_ff.pose_x};
         REG_POSE_Y:           csr_prdata = {8'd0, cfg_ff.pose_y};
         REG_POSE_HEADING:     csr_prdata = {16'd0, cfg_ff.pose_heading};
         REG_POSE_VALID:       csr_prdata = {31'd0, cfg_ff.pose_valid};
         default:              csr_prdata = '0;
      endcase
   end

   // The front end folds each sample into the running sector figures and,
   // on the last sample, hands the whole scan to the queue as one job.
   lss_front #(
      .MAX_BEAMS   (MAX_BEAMS),
      .NO_RETURN_MM(NO_RETURN_MM)
   ) u_front (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_tvalid),
      .req_ready  (req_tready),
      .range_mm   (req_tdata[15:0]),
      .beam_index (req_tdata[25:16]),
      .last_sample(req_tlast),
      .goal_x     (req_tdata[49:26]),
      .goal_y     (req_tdata[73:50]),
      .cfg        (cfg_ff),
      .queue_full (full),
      .push       (push),
      .push_job   (push_job)
   );

   // Two scans may wait here while the back end works, so the next scan
   // streams in without stalling while a place is free.
   lss_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .push_job (push_job),
      .full     (full),
      .pop      (pop),
      .pop_job  (pop_job),
      .not_empty(not_empty)
   );

   // The back end works out averages, distance and bearing for one job at a
   // time and keeps the result in its own register until it is taken.
   lss_back #(
      .CORDIC_STEPS(CORDIC_STEPS)
   ) u_back (
      .clock    (clock),
      .reset    (reset),
      .cfg      (cfg_ff),
      .job_ready(not_empty),
      .job      (pop_job),
      .pop      (pop),
      .rsp_valid(rsp_tvalid),
      .rsp_ready(rsp_tready),
      .result   (result)
   );

   assign rsp_tuser = result.summary_valid;
   assign rsp_tdata = {7'd0, result.heading_error, result.goal_distance_mm,
                       result.right_avg_mm, result.left_avg_mm, result.front_min_mm};
endmodule
`default_nettype wire

@@ tb/sv/lidar_sector_summary_test.sv @@
// Self-checking testbench for the lidar sector summary block.
// Depends on lss_pkg and lidar_sector_summary from the hdl folder.
`default_nettype none
module lidar_sector_summary_test;
   import lss_pkg::*;

   localparam int NO_RETURN = 10000;
   localparam int STEPS     = 16;
   localparam int LIMIT     = 600000;

   logic         clock = 1'b0;
   logic         reset = 1'b1;
   logic         req_tvalid = 1'b0;
   logic         req_tready;
   logic [79:0]  req_tdata = '0;
   logic         req_tlast = 1'b0;
   logic         rsp_tvalid;
   logic         rsp_tready = 1'b0;
   logic [95:0]  rsp_tdata;
   logic         rsp_tuser;
   logic         csr_psel = 1'b0;
   logic         csr_penable = 1'b0;
   logic         csr_pwrite = 1'b0;
   logic [4:0]   csr_paddr = '0;
   logic [31:0]  csr_pwdata = '0;
   logic [31:0]  csr_prdata;
   logic         csr_pready;

   lidar_sector_summary uut (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready),
      .req_tdata(req_tdata), .req_tlast(req_tlast),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready),
      .rsp_tdata(rsp_tdata), .rsp_tuser(rsp_tuser),
      .csr_psel(csr_psel), .csr_penable(csr_penable), .csr_pwrite(csr_pwrite),
      .csr_paddr(csr_paddr), .csr_pwdata(csr_pwdata),
      .csr_prdata(csr_prdata), .csr_pready(csr_pready)
   );

   always #5 clock = ~clock;

   // The predictor keeps its own copy of the registers and of the scan figures.
   cfg_type      shadow_cfg;
   logic [15:0]  scan_front_min;
   logic [25:0]  scan_left_sum, scan_right_sum;
   logic [10:0]  scan_left_count, scan_right_count;
   res_type      pending_summaries[$];

   int           mismatches = 0;
   int           cycle_count = 0;
   bit           hold_off = 1'b0;   // set while the receiver is made to stall for long
   bit           burst_mode = 1'b1; // lets the sender idle between bursts

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > LIMIT) begin
         $display("TB_ERROR");
         $finish;
      end
   end

   function automatic logic [24:0] rounded_root(input logic [63:0] n);
      logic [63:0] rem, root, bit_val;
      rem = n;
      root = '0;
      bit_val = 64'd1 << 50;
      while (bit_val > rem) bit_val = bit_val >> 2;
      while (bit_val != 0) begin
         if (rem >= root + bit_val) begin
            rem = rem - (root + bit_val);
            root = (root >> 1) + bit_val;
         end else begin
            root = root >> 1;
         end
         bit_val = bit_val >> 2;
      end
      if (n - root * root > root) root = root + 64'd1;
      return root[24:0];
   endfunction

   // Arithmetic shift right with floor rounding, as the vectoring loop needs.
   function automatic logic signed [63:0] floor_shift(input logic signed [63:0] v, input int s);
      return v >>> s;
   endfunction

   function automatic logic [31:0] goal_bearing(input longint dx, input longint dy);
      longint      x, y, xs, ys;
      logic [31:0] angle;
      x = dx * (64'sd1 <<< 30);
      y = dy * (64'sd1 <<< 30);
      angle = '0;
      if (dx == 0 && dy == 0) return 32'd0;
      // Goals behind the robot are turned through half a revolution first.
      if (x < 0) begin
         x = -x;
         y = -y;
         angle = 32'h8000_0000;
      end
      for (int i = 0; i < STEPS; i++) begin
         xs = floor_shift(x, i);
         ys = floor_shift(y, i);
         if (y > 0) begin
            x = x + ys; y = y - xs; angle = angle + ATAN_TURN[i];
         end else begin
            x = x - ys; y = y + xs; angle = angle - ATAN_TURN[i];
         end
      end
      return angle;
   endfunction

   function automatic logic [15:0] sector_mean(input logic [25:0] sum, input logic [10:0] count);
      logic [25:0] quotient;
      if (count == 0) return 16'd0;
      quotient = sum / count;
      return (quotient > 26'd65535) ? 16'hFFFF : quotient[15:0];
   endfunction

   task automatic clear_scan_figures();
      scan_front_min = 16'(NO_RETURN);
      scan_left_sum = '0; scan_right_sum = '0;
      scan_left_count = '0; scan_right_count = '0;
   endtask

   // Folds one accepted sample into the scan figures and, on the last one, queues a summary.
   task automatic predict_sample(input logic [15:0] range_mm, input logic [9:0] beam,
                                 input logic last, input logic signed [23:0] gx,
                                 input logic signed [23:0] gy);
      logic [15:0] range_sub;
      logic [26:0] widened;
      res_type     s;
      longint      dx, dy;
      logic [63:0] sq;
      logic [31:0] err;
      range_sub = (range_mm == 0 || range_mm == 16'hFFFF) ? 16'(NO_RETURN) : range_mm;
      if (beam <= shadow_cfg.front_low_end || beam >= shadow_cfg.front_high_start) begin
         if (range_sub < scan_front_min) scan_front_min = range_sub;
      end else if (beam <= shadow_cfg.left_end) begin
         widened = scan_left_sum + range_sub;
         scan_left_sum = (widened > SUM_MAX) ? SUM_MAX : widened[25:0];
         if (scan_left_count < COUNT_MAX) scan_left_count++;
      end else if (beam >= shadow_cfg.right_start) begin
         widened = scan_right_sum + range_sub;
         scan_right_sum = (widened > SUM_MAX) ? SUM_MAX : widened[25:0];
         if (scan_right_count < COUNT_MAX) scan_right_count++;
      end
      if (!last) return;
      s = '0;
      if (shadow_cfg.pose_valid) begin
         dx = longint'(gx) - longint'(shadow_cfg.pose_x);
         dy = longint'(gy) - longint'(shadow_cfg.pose_y);
         sq = dx * dx + dy * dy;
         err = goal_bearing(dx, dy) - {shadow_cfg.pose_heading, 16'h0000};
         s.summary_valid = 1'b1;
         s.front_min_mm = scan_front_min;
         s.left_avg_mm = sector_mean(scan_left_sum, scan_left_count);
         s.right_avg_mm = sector_mean(scan_right_sum, scan_right_count);
         s.goal_distance_mm = rounded_root(sq);
         s.heading_error = 16'((err + 32'h8000) >> 16);
      end
      pending_summaries.push_back(s);
      clear_scan_figures();
   endtask

   // Checks every accepted summary against the oldest prediction.
   always @(posedge clock) begin
      res_type got, want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got.summary_valid = rsp_tuser;
         got.front_min_mm = rsp_tdata[15:0];
         got.left_avg_mm = rsp_tdata[31:16];
         got.right_avg_mm = rsp_tdata[47:32];
         got.goal_distance_mm = rsp_tdata[72:48];
         got.heading_error = rsp_tdata[88:73];
         if (pending_summaries.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("unexpected summary %p", got);
         end else begin
            want = pending_summaries.pop_front();
            if (got !== want) begin
               mismatches++;
               if (mismatches <= 10) $display("summary mismatch: expected %p, got %p", want, got);
            end
         end
      end
   end

   // The receiver stalls on a slowly changing pattern, or for long while held off.
   always @(posedge clock) begin
      int phase;
      phase = cycle_count % 64;
      if (hold_off) rsp_tready <= 1'b0;
      else if (phase < 16) rsp_tready <= 1'b1;
      else rsp_tready <= ($urandom_range(0, 3) != 0);
   end

   task automatic write_register(input reg_index_type index, input logic [31:0] value);
      csr_psel <= 1'b1; csr_penable <= 1'b0; csr_pwrite <= 1'b1;
      csr_paddr <= 5'(index) << 2; csr_pwdata <= value;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      csr_psel <= 1'b0; csr_penable <= 1'b0; csr_pwrite <= 1'b0;
      case (index)
         REG_FRONT_LOW_END:    shadow_cfg.front_low_end = value[9:0];
         REG_LEFT_END:         shadow_cfg.left_end = value[9:0];
         REG_RIGHT_START:      shadow_cfg.right_start = value[9:0];
         REG_FRONT_HIGH_START: shadow_cfg.front_high_start = value[9:0];
         REG_POSE_X:           shadow_cfg.pose_x = value[23:0];
         REG_POSE_Y:           shadow_cfg.pose_y = value[23:0];
         REG_POSE_HEADING:     shadow_cfg.pose_heading = value[15:0];
         REG_POSE_VALID:       shadow_cfg.pose_valid = value[0];
         default: ;
      endcase
   endtask

   // Sends one sample request; in burst mode the sender may first pause for a random while.
   task automatic send_sample(input logic [15:0] range_mm, input logic [9:0] beam,
                              input logic last, input logic signed [23:0] gx,
                              input logic signed [23:0] gy);
      if (burst_mode && $urandom_range(0, 9) == 0) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 6)) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata <= {6'b0, gy, gx, beam, range_mm};
      req_tlast <= last;
      do @(posedge clock); while (!req_tready);
      predict_sample(range_mm, beam, last, gx, gy);
   endtask

   task automatic stop_sending();
      req_tvalid <= 1'b0;
      @(posedge clock);
   endtask

   // Waits until every summary has arrived, then lets the back end settle.
   task automatic drain();
      stop_sending();
      while (pending_summaries.size() != 0) @(posedge clock);
      repeat (40) @(posedge clock);
   endtask

   function automatic logic [15:0] random_range_value();
      case ($urandom_range(0, 5))
         0: return 16'h0000;
         1: return 16'hFFFF;
         2: return 16'($urandom_range(1, 200));
         default: return 16'($urandom);
      endcase
   endfunction

   task automatic send_scan(input int beams, input bit random_beams);
      logic signed [23:0] gx, gy;
      gx = 24'($urandom);
      gy = 24'($urandom);
      if ($urandom_range(0, 3) == 0) begin
         gx = shadow_cfg.pose_x + 24'($urandom_range(0, 64)) - 24'sd32;
         gy = shadow_cfg.pose_y;
      end
      for (int b = 0; b < beams; b++)
         send_sample(random_range_value(),
                     random_beams ? 10'($urandom) : 10'(b * (1024 / beams)),
                     b == beams - 1, gx, gy);
   endtask

   // Pose not yet written: the summary is marked invalid and zeroed.
   task automatic test_without_pose();
      send_sample(16'd500, 10'd0, 1'b0, 24'sd0, 24'sd0);
      send_sample(16'd700, 10'd50, 1'b1, 24'sd100, 24'sd100);
      drain();
   endtask

   // Field extremes, missing returns, empty sectors and a goal at the pose.
   task automatic test_directed();
      write_register(REG_POSE_X, 32'h0080_0000);
      write_register(REG_POSE_Y, 32'h007F_FFFF);
      write_register(REG_POSE_HEADING, 32'h0000_8000);
      write_register(REG_POSE_VALID, 32'd1);
      send_sample(16'h0000, 10'd0, 1'b0, 24'sd0, 24'sd0);
      send_sample(16'hFFFF, 10'd1023, 1'b0, 24'sd0, 24'sd0);
      send_sample(16'd1, 10'd40, 1'b0, 24'sd0, 24'sd0);
      send_sample(16'hFFFE, 10'd60, 1'b0, 24'sd0, 24'sd0);
      send_sample(16'd300, 10'd300, 1'b0, 24'sd0, 24'sd0);
      send_sample(16'd20, 10'd200, 1'b1, 24'h7F_FFFF, 24'h80_0000);
      // Only front samples: both side averages are zero; goal at the pose.
      send_sample(16'd5, 10'd10, 1'b1, 24'h80_0000, 24'h7F_FFFF);
      drain();
      write_register(REG_POSE_X, 32'd0);
      write_register(REG_POSE_Y, 32'd0);
      write_register(REG_POSE_HEADING, 32'h0000_7FFF);
      // Goals on each axis, including straight behind the robot.
      send_sample(16'd900, 10'd100, 1'b1, 24'sd1000, 24'sd0);
      send_sample(16'd900, 10'd100, 1'b1, -24'sd1000, 24'sd0);
      send_sample(16'd900, 10'd100, 1'b1, 24'sd0, 24'sd1000);
      send_sample(16'd900, 10'd100, 1'b1, 24'sd0, -24'sd1000);
      send_sample(16'd900, 10'd100, 1'b1, -24'sd3, -24'sd7);
      drain();
   endtask

   // A long scan over one wide left sector builds a large sum near full range.
   task automatic test_long_scan();
      write_register(REG_FRONT_LOW_END, 32'd0);
      write_register(REG_LEFT_END, 32'd1023);
      write_register(REG_RIGHT_START, 32'd1023);
      write_register(REG_FRONT_HIGH_START, 32'd1023);
      for (int i = 0; i < 100; i++)
         send_sample(16'hFFFE, 10'd500, i == 99, 24'sd5, 24'sd5);
      drain();
   endtask

   // Random scans under several sector layouts, the extremes among them.
   task automatic test_random_scans();
      for (int layout = 0; layout < 6; layout++) begin
         case (layout)
            0: begin
               write_register(REG_FRONT_LOW_END, 32'd30);
               write_register(REG_LEFT_END, 32'd90);
               write_register(REG_RIGHT_START, 32'd270);
               write_register(REG_FRONT_HIGH_START, 32'd330);
            end
            1: begin
               write_register(REG_FRONT_LOW_END, 32'd1023);
               write_register(REG_FRONT_HIGH_START, 32'd0);
            end
            2: begin
               write_register(REG_FRONT_LOW_END, 32'd100);
               write_register(REG_LEFT_END, 32'd50);
               write_register(REG_RIGHT_START, 32'd0);
               write_register(REG_FRONT_HIGH_START, 32'd900);
            end
            default: begin
               write_register(REG_FRONT_LOW_END, $urandom_range(0, 1023));
               write_register(REG_LEFT_END, $urandom_range(0, 1023));
               write_register(REG_RIGHT_START, $urandom_range(0, 1023));
               write_register(REG_FRONT_HIGH_START, $urandom_range(0, 1023));
            end
         endcase
         write_register(REG_POSE_X, $urandom);
         write_register(REG_POSE_Y, $urandom);
         write_register(REG_POSE_HEADING, $urandom);
         write_register(REG_POSE_VALID, 32'(layout != 4));
         for (int s = 0; s < 10; s++)
            send_scan($urandom_range(1, 16), s % 3 == 0);
         drain();
      end
   endtask

   // The receiver holds off for a long stretch while one-sample scans keep coming.
   task automatic test_backpressure();
      write_register(REG_POSE_VALID, 32'd1);
      burst_mode = 1'b0;
      fork
         begin
            hold_off = 1'b1;
            repeat (400) @(posedge clock);
            hold_off = 1'b0;
         end
         for (int i = 0; i < 60; i++) send_scan(1, 1'b1);
      join
      burst_mode = 1'b1;
      drain();
   endtask

   initial begin
      shadow_cfg = '{front_low_end: 10'd30, left_end: 10'd90, right_start: 10'd270,
                     front_high_start: 10'd330, default: '0};
      clear_scan_figures();
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_without_pose();
      test_directed();
      test_random_scans();
      test_backpressure();
      test_long_scan();
      if (mismatches == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end

endmodule
`default_nettype wire
